>>> hw/rtl/ohlc_candle_aggregator_defines.svh
// ----------------------------------------------------------------------------
// OHLC candle aggregator assertion macros
// Shared concurrent assertion forms; compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef OHLC_CANDLE_AGGREGATOR_DEFINES_SVH
`define OHLC_CANDLE_AGGREGATOR_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define OHLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ohlc: implication check failed");

// next-cycle implication
`define OHLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ohlc: next-cycle check failed");

// invariant
`define OHLC_ASSERT_ALW(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("ohlc: invariant check failed");

`else

`define OHLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define OHLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`define OHLC_ASSERT_ALW(lbl, clk, rst_n, cond)

`endif

`endif

>>> hw/rtl/ohlc_pkg.sv
// ----------------------------------------------------------------------------
// OHLC package
// Types, widths and codes shared by the candle aggregator modules.
// ----------------------------------------------------------------------------
package ohlc_pkg;

	localparam int HIST_DEPTH = 32;
	localparam int PRICE_W    = 32;
	localparam int TIME_W     = 40;
	localparam int IVL_W      = 17;
	localparam int LIMIT_W    = 6;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = TIME_W;

	localparam logic [IVL_W-1:0]  IVL_RESET   = IVL_W'(60);
	localparam logic [TIME_W-1:0] START_RESET = '0;

	// request codes
	localparam logic [1:0] REQ_TRADE = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_START    = 1'b1;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [PRICE_W-1:0] price;
		logic [LIMIT_W-1:0] limit;
	} in_item_t;

	typedef struct packed {
		logic               has_data;
		logic [PRICE_W-1:0] open_price;
		logic [PRICE_W-1:0] high_price;
		logic [PRICE_W-1:0] low_price;
		logic [PRICE_W-1:0] close_price;
		logic [TIME_W-1:0]  bar_time;
		logic               last_bar;
	} out_item_t;

	// one stored bar
	typedef struct packed {
		logic [PRICE_W-1:0] open_p;
		logic [PRICE_W-1:0] high_p;
		logic [PRICE_W-1:0] low_p;
		logic [PRICE_W-1:0] close_p;
		logic [TIME_W-1:0]  stamp;
	} bar_t;

	// ring pointer status
	typedef struct packed {
		logic [HIST_AW-1:0] head;
		logic [CNT_W-1:0]   count;
	} hist_status_t;

	// previous ring slot, wrapping at the bottom
	function automatic logic [HIST_AW-1:0] hist_prev(input logic [HIST_AW-1:0] slot);
		logic [HIST_AW-1:0] r;
		if (slot == '0) begin
			r = HIST_AW'(HIST_DEPTH - 1);
		end else begin
			r = slot - 1'b1;
		end
		return r;
	endfunction

	// next ring slot, wrapping at the top
	function automatic logic [HIST_AW-1:0] hist_next(input logic [HIST_AW-1:0] slot);
		logic [HIST_AW-1:0] r;
		if (slot == HIST_AW'(HIST_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = slot + 1'b1;
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/ohlc_hist_ring.sv
// ----------------------------------------------------------------------------
// OHLC history ring
// Bar memory with one write and one registered read port, plus head/count.
// ----------------------------------------------------------------------------
`include "ohlc_candle_aggregator_defines.svh"

module ohlc_hist_ring (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  ohlc_pkg::bar_t                wr_bar,
	input  logic                          rd_en,
	input  logic [ohlc_pkg::HIST_AW-1:0]  rd_addr,
	output ohlc_pkg::bar_t                rd_bar,
	output ohlc_pkg::hist_status_t        status
);
	import ohlc_pkg::*;

	bar_t               mem [HIST_DEPTH];
	bar_t               rd_q;
	logic [HIST_AW-1:0] head_q;
	logic [CNT_W-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[head_q] <= wr_bar;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (push) begin
			head_q <= hist_next(head_q);
			if (count_q != CNT_W'(HIST_DEPTH)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	assign rd_bar       = rd_q;
	assign status.head  = head_q;
	assign status.count = count_q;

	`OHLC_ASSERT_ALW(a_count_bound, clk, arst_n, count_q <= CNT_W'(HIST_DEPTH))
	`OHLC_ASSERT_NXT(a_count_grow, clk, arst_n, push && (count_q != CNT_W'(HIST_DEPTH)), count_q == $past(count_q) + 1'b1)
	`OHLC_ASSERT_NXT(a_head_moves, clk, arst_n, push, head_q != $past(head_q))

endmodule

>>> hw/rtl/ohlc_candle_aggregator.sv
// ----------------------------------------------------------------------------
// OHLC candle aggregator
// Builds open/high/low/close bars from trade prices and files them into a
// history ring on interval ticks; queries stream back current + history bars.
// ----------------------------------------------------------------------------
//
//  channel | signals                         | moves
//  --------+---------------------------------+---------------------------------
//  in      | in_valid / in_ready / in_item   | trade, interval tick or query item
//  out     | out_valid / out_ready / out_item| one bar item per query result
//  cfg     | cfg_we / cfg_idx / cfg_wdata    | interval length, start time
//
//  Trades and ticks may arrive every cycle while no query streams.
//  A query is accepted, then the current bar is emitted, then each history bar
//  is a read of the single history port followed by a load of the output
//  register, for n = min(limit, stored bars) bars; an out stall holds the walk.
//  While a query streams, in_ready stays low; the output register lets the
//  next trade/tick in while the last query item still waits to be taken.
//  Reset: control and pointers clear at once; the history memory is not cleared
//  (entries are only read after being written), so no sweep is needed.
//
`include "ohlc_candle_aggregator_defines.svh"

module ohlc_candle_aggregator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  ohlc_pkg::in_item_t               in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output ohlc_pkg::out_item_t              out_item,
	input  logic                             cfg_we,
	input  logic [ohlc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [ohlc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import ohlc_pkg::*;

	// query sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;  // taking items
	localparam logic [1:0] ST_HEAD = 2'd1;  // emit current (or flat) bar
	localparam logic [1:0] ST_READ = 2'd2;  // issue history read
	localparam logic [1:0] ST_LOAD = 2'd3;  // history data ready, load output

	localparam int CMP_W = (LIMIT_W > CNT_W) ? LIMIT_W : CNT_W;

	logic [1:0]         state_q;

	// configuration
	logic [IVL_W-1:0]   interval_q;

	// current bar
	logic [PRICE_W-1:0] cur_open_q, cur_high_q, cur_low_q, cur_close_q;
	logic               cur_empty_q;
	logic [TIME_W-1:0]  cur_time_q;

	// newest stored close, mirrors the ring's newest entry
	logic [PRICE_W-1:0] last_close_q;

	// query walk
	logic [CNT_W-1:0]   nleft_q;
	logic [HIST_AW-1:0] rd_slot_q;

	// output register
	logic               out_valid_q;
	out_item_t          out_q;

	logic               in_acc;
	logic               out_free;
	logic               push;
	bar_t               wr_bar;
	logic               rd_en;
	bar_t               rd_bar;
	hist_status_t       hstat;
	logic [CMP_W-1:0]   lim_ext, cnt_ext;
	logic [CNT_W-1:0]   nq;
	logic               nothing_yet;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// a tick files the live bar, or a flat bar once history exists
	assign push = in_acc && (in_item.req_type == REQ_TICK) &&
		(!cur_empty_q || (hstat.count != '0));

	always_comb begin
		if (cur_empty_q) begin
			wr_bar = '{open_p: last_close_q, high_p: last_close_q,
				low_p: last_close_q, close_p: last_close_q, stamp: cur_time_q};
		end else begin
			wr_bar = '{open_p: cur_open_q, high_p: cur_high_q,
				low_p: cur_low_q, close_p: cur_close_q, stamp: cur_time_q};
		end
	end

	// history bars returned: limit clipped to what is stored
	assign lim_ext     = CMP_W'(in_item.limit);
	assign cnt_ext     = CMP_W'(hstat.count);
	assign nq          = (lim_ext > cnt_ext) ? hstat.count : CNT_W'(in_item.limit);
	assign nothing_yet = cur_empty_q && (hstat.count == '0);

	assign rd_en = (state_q == ST_READ);

	ohlc_hist_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_bar  (wr_bar),
		.rd_en   (rd_en),
		.rd_addr (rd_slot_q),
		.rd_bar  (rd_bar),
		.status  (hstat)
	);

	// configuration and current bar
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= IVL_RESET;
			cur_time_q  <= START_RESET;
			cur_empty_q <= 1'b1;
			cur_open_q  <= '0;
			cur_high_q  <= '0;
			cur_low_q   <= '0;
			cur_close_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_INTERVAL: interval_q <= cfg_wdata[IVL_W-1:0];
				CFG_START:    cur_time_q <= cfg_wdata[TIME_W-1:0];
				default: ;
			endcase
		end else if (in_acc) begin
			unique case (in_item.req_type)
				REQ_TRADE: begin
					cur_close_q <= in_item.price;
					if (cur_empty_q) begin
						cur_open_q  <= in_item.price;
						cur_high_q  <= in_item.price;
						cur_low_q   <= in_item.price;
						cur_empty_q <= 1'b0;
					end else if (in_item.price > cur_high_q) begin
						cur_high_q <= in_item.price;
					end else if (in_item.price < cur_low_q) begin
						cur_low_q <= in_item.price;
					end
				end
				REQ_TICK: begin
					cur_open_q  <= '0;
					cur_high_q  <= '0;
					cur_low_q   <= '0;
					cur_close_q <= '0;
					cur_empty_q <= 1'b1;
					cur_time_q  <= cur_time_q + TIME_W'(interval_q);
				end
				default: ;
			endcase
		end
	end

	// flat-bar source; only read once something has been filed
	always_ff @(posedge clk) begin
		if (push) begin
			last_close_q <= wr_bar.close_p;
		end
	end

	// query sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_item.req_type == REQ_QUERY)) begin
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					if (out_free) begin
						state_q <= (nleft_q == '0) ? ST_IDLE : ST_READ;
					end
				end
				ST_READ: state_q <= ST_LOAD;
				ST_LOAD: begin
					if (out_free) begin
						state_q <= (nleft_q == '0) ? ST_IDLE : ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// walk pointers: newest slot first, count down bars left
	always_ff @(posedge clk) begin
		if (in_acc && (in_item.req_type == REQ_QUERY)) begin
			nleft_q   <= nq;
			rd_slot_q <= hist_prev(hstat.head);
		end else if (state_q == ST_READ) begin
			nleft_q   <= nleft_q - 1'b1;
			rd_slot_q <= hist_prev(rd_slot_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (((state_q == ST_HEAD) || (state_q == ST_LOAD)) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_HEAD) && out_free) begin
			if (nothing_yet) begin
				out_q.has_data    <= 1'b0;
				out_q.open_price  <= '0;
				out_q.high_price  <= '0;
				out_q.low_price   <= '0;
				out_q.close_price <= '0;
				out_q.bar_time    <= '0;
				out_q.last_bar    <= 1'b1;
			end else begin
				out_q.has_data    <= 1'b1;
				out_q.open_price  <= wr_bar.open_p;
				out_q.high_price  <= wr_bar.high_p;
				out_q.low_price   <= wr_bar.low_p;
				out_q.close_price <= wr_bar.close_p;
				out_q.bar_time    <= cur_time_q;
				out_q.last_bar    <= (nleft_q == '0);
			end
		end else if ((state_q == ST_LOAD) && out_free) begin
			out_q.has_data    <= 1'b1;
			out_q.open_price  <= rd_bar.open_p;
			out_q.high_price  <= rd_bar.high_p;
			out_q.low_price   <= rd_bar.low_p;
			out_q.close_price <= rd_bar.close_p;
			out_q.bar_time    <= rd_bar.stamp;
			out_q.last_bar    <= (nleft_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`OHLC_ASSERT_IMP(a_busy_no_take, clk, arst_n, state_q != ST_IDLE, !in_ready && !push)
	`OHLC_ASSERT_IMP(a_empty_is_last, clk, arst_n, out_valid_q && !out_q.has_data, out_q.last_bar)
	`OHLC_ASSERT_NXT(a_read_then_load, clk, arst_n, state_q == ST_READ, state_q == ST_LOAD)

endmodule
